// File: design/psms_pkg.sv
// ----------------------------------------------------------------------------
// psms_pkg
// Shared constants for the point set mean and deviation block.
// ----------------------------------------------------------------------------
package psms_pkg;

  localparam int DEF_MAX_POINTS  = 65536;
  localparam int DEF_COORD_WIDTH = 24;

  // Width of the reported point count.
  localparam int PTS_W = 17;

  localparam int NUM_AXES = 3;

endpackage

// File: design/point_set_mean_std_top.sv
// ----------------------------------------------------------------------------
// point_set_mean_std_top
// Per-axis mean and population standard deviation of a set of 3D points.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  in       to block   in_valid/in_stall    in_coord_x/y/z, in_final_point
//  out      from block out_valid/out_stall  out_mean_x/y/z, out_spread_x/y/z,
//                                           out_points_used, out_count_overflow
//
// A point is taken in the accepting cycle; then for each axis a step adds the
// coordinate while squaring it and a step adds the square, both through the
// shared adder. A point that arrives when the count is full is dropped and
// flags the overflow; a final one among them still starts the finish sequence.
// The last point of a set then runs the finish sequence, per axis: sum
// magnitude, division for the mean, floor fix, n * sum of squares, square of
// the sum, difference, square root, division for the spread; then the result is loaded.
// Reset is synchronous and clears the sequencer, the point count and the per-axis sums.
// The input may be taken while an earlier result waits under out_stall; the
// block holds at the end of the finish sequence until that result is taken.

module point_set_mean_std_top
  import psms_pkg::*;
#(
  parameter int MAX_POINTS  = DEF_MAX_POINTS,
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [COORD_WIDTH-1:0] in_coord_x,
  input  logic [COORD_WIDTH-1:0] in_coord_y,
  input  logic [COORD_WIDTH-1:0] in_coord_z,
  input  logic                   in_final_point,

  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [COORD_WIDTH-1:0] out_mean_x,
  output logic [COORD_WIDTH-1:0] out_mean_y,
  output logic [COORD_WIDTH-1:0] out_mean_z,
  output logic [COORD_WIDTH-2:0] out_spread_x,
  output logic [COORD_WIDTH-2:0] out_spread_y,
  output logic [COORD_WIDTH-2:0] out_spread_z,
  output logic [PTS_W-1:0]       out_points_used,
  output logic                   out_count_overflow
);

  localparam int CW   = COORD_WIDTH;
  localparam int NW   = $clog2(MAX_POINTS + 1);
  localparam int RW   = CW + NW;
  localparam int SQW  = 2 * CW + NW;
  localparam int DW   = 2 * RW;
  localparam int AW   = DW + 2;
  localparam int CNTW = $clog2(RW);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC_SUM,
    S_ACC_SQ,
    S_MAG,
    S_DIV,
    S_MEAN_FIX,
    S_NSQ,
    S_SQM,
    S_DIFF,
    S_SQRT,
    S_DONE
  } state_t;

  state_t              state_r;
  logic [1:0]          axis_r;
  logic [CNTW-1:0]     cnt_r;
  logic                final_r;
  logic                div_spread_r;

  logic [NW-1:0]       tally_r;
  logic                dropped_r;
  logic [RW-1:0]       sum_r     [NUM_AXES];
  logic [SQW-1:0]      sq_r      [NUM_AXES];
  logic [CW-1:0]       coord_r   [NUM_AXES];
  logic [2*CW-1:0]     prod_r;

  logic                neg_r;
  logic [RW-1:0]       mag_r;
  logic [RW-1:0]       quo_r;
  logic [NW-1:0]       rem_r;
  logic [NW-1:0]       nsh_r;
  logic [DW-1:0]       acc_r;
  logic [DW-1:0]       t_r;
  logic [RW-1:0]       root_r;

  logic [CW-1:0]       res_mean_r   [NUM_AXES];
  logic [CW-2:0]       res_spread_r [NUM_AXES];

  logic                out_valid_r;
  logic [CW-1:0]       out_mean_r   [NUM_AXES];
  logic [CW-2:0]       out_spread_r [NUM_AXES];
  logic [PTS_W-1:0]    out_points_r;
  logic                out_ovf_r;

  // Shared adder and its operand selection.
  logic [AW-1:0]       alu_a;
  logic [AW-1:0]       alu_b;
  logic                alu_sub;
  logic [AW-1:0]       alu_y;
  logic                alu_neg;

  logic [RW-1:0]       sum_cur;
  logic [SQW-1:0]      sq_cur;
  logic [CW-1:0]       coord_cur;
  logic [CW-1:0]       coord_mag;
  logic [2*CW-1:0]     sq_prod;
  logic [RW-1:0]       coord_sext;
  logic [NW:0]         div_shift;
  logic                div_ok;
  logic [RW-1:0]       quo_nxt;
  logic [RW+2:0]       sqrt_trem;
  logic                sqrt_ok;
  logic [RW-1:0]       mag_nxt;
  logic [RW-1:0]       mean_fix;
  logic                last_axis;

  assign sum_cur    = sum_r[axis_r];
  assign sq_cur     = sq_r[axis_r];
  assign coord_cur  = coord_r[axis_r];
  assign coord_mag  = coord_cur[CW-1] ? (~coord_cur + CW'(1)) : coord_cur;
  assign sq_prod    = (2*CW)'(coord_mag) * (2*CW)'(coord_mag);
  assign coord_sext = {{(RW-CW){coord_cur[CW-1]}}, coord_cur};
  assign div_shift  = {rem_r, quo_r[RW-1]};
  assign sqrt_trem  = {t_r[RW:0], acc_r[DW-1 -: 2]};
  assign last_axis  = (axis_r == 2'(NUM_AXES - 1));

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r)
      S_ACC_SUM: begin
        alu_a = AW'(sum_cur);
        alu_b = AW'(coord_sext);
      end
      S_ACC_SQ: begin
        alu_a = AW'(sq_cur);
        alu_b = AW'(prod_r);
      end
      S_MAG: begin
        alu_b   = AW'(sum_cur);
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = AW'(div_shift);
        alu_b   = AW'(tally_r);
        alu_sub = 1'b1;
      end
      S_MEAN_FIX: begin
        alu_b   = AW'(quo_r);
        alu_sub = 1'b1;
      end
      S_NSQ: begin
        alu_a = AW'({acc_r[DW-2:0], 1'b0});
        alu_b = nsh_r[NW-1] ? AW'(sq_cur) : '0;
      end
      S_SQM: begin
        alu_a = AW'({t_r[DW-2:0], 1'b0});
        alu_b = quo_r[RW-1] ? AW'(mag_r) : '0;
      end
      S_DIFF: begin
        alu_a   = AW'(acc_r);
        alu_b   = AW'(t_r);
        alu_sub = 1'b1;
      end
      S_SQRT: begin
        alu_a   = AW'(sqrt_trem);
        alu_b   = AW'({root_r, 2'b01});
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_y   = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  assign alu_neg = alu_y[AW-1];

  assign div_ok   = !alu_neg;
  assign quo_nxt  = {quo_r[RW-2:0], div_ok};
  assign sqrt_ok  = !alu_neg;
  assign mag_nxt  = sum_cur[RW-1] ? alu_y[RW-1:0] : sum_cur;
  // Floor of a negative quotient: -(q+1) is ~q when there is a remainder.
  assign mean_fix = !neg_r ? quo_r : ((rem_r != '0) ? ~quo_r : alu_y[RW-1:0]);

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      axis_r       <= '0;
      cnt_r        <= '0;
      div_spread_r <= 1'b0;
      out_valid_r  <= 1'b0;
      tally_r      <= '0;
      dropped_r    <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        sum_r[i] <= '0;
        sq_r[i]  <= '0;
      end
    end else begin
      // In S_DONE the result load below owns the valid flag.
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            coord_r[0] <= in_coord_x;
            coord_r[1] <= in_coord_y;
            coord_r[2] <= in_coord_z;
            final_r    <= in_final_point;
            axis_r     <= '0;
            if (tally_r == NW'(MAX_POINTS)) begin
              dropped_r <= 1'b1;
              if (in_final_point) begin
                state_r <= S_MAG;
              end
            end else begin
              state_r <= S_ACC_SUM;
            end
          end
        end

        S_ACC_SUM: begin
          sum_r[axis_r] <= alu_y[RW-1:0];
          prod_r        <= sq_prod;
          state_r       <= S_ACC_SQ;
        end

        S_ACC_SQ: begin
          sq_r[axis_r] <= alu_y[SQW-1:0];
          if (last_axis) begin
            axis_r  <= '0;
            tally_r <= tally_r + NW'(1);
            state_r <= final_r ? S_MAG : S_IDLE;
          end else begin
            axis_r  <= axis_r + 2'd1;
            state_r <= S_ACC_SUM;
          end
        end

        S_MAG: begin
          neg_r        <= sum_cur[RW-1];
          mag_r        <= mag_nxt;
          quo_r        <= mag_nxt;
          rem_r        <= '0;
          cnt_r        <= '0;
          div_spread_r <= 1'b0;
          state_r      <= S_DIV;
        end

        // Restoring division by the point count, one quotient bit a cycle.
        S_DIV: begin
          rem_r <= div_ok ? alu_y[NW-1:0] : div_shift[NW-1:0];
          quo_r <= quo_nxt;
          if (cnt_r == CNTW'(RW - 1)) begin
            cnt_r <= '0;
            if (div_spread_r) begin
              res_spread_r[axis_r] <= quo_nxt[CW-2:0];
              if (last_axis) begin
                state_r <= S_DONE;
              end else begin
                axis_r  <= axis_r + 2'd1;
                state_r <= S_MAG;
              end
            end else begin
              state_r <= S_MEAN_FIX;
            end
          end else begin
            cnt_r <= cnt_r + CNTW'(1);
          end
        end

        S_MEAN_FIX: begin
          res_mean_r[axis_r] <= mean_fix[CW-1:0];
          acc_r              <= '0;
          nsh_r              <= tally_r;
          cnt_r              <= '0;
          state_r            <= S_NSQ;
        end

        // n * sum of squares, shift and add over the bits of n.
        S_NSQ: begin
          acc_r <= alu_y[DW-1:0];
          nsh_r <= {nsh_r[NW-2:0], 1'b0};
          if (cnt_r == CNTW'(NW - 1)) begin
            cnt_r   <= '0;
            t_r     <= '0;
            quo_r   <= mag_r;
            state_r <= S_SQM;
          end else begin
            cnt_r <= cnt_r + CNTW'(1);
          end
        end

        // Square of the sum magnitude, shift and add over its bits.
        S_SQM: begin
          t_r   <= alu_y[DW-1:0];
          quo_r <= {quo_r[RW-2:0], 1'b0};
          if (cnt_r == CNTW'(RW - 1)) begin
            cnt_r   <= '0;
            state_r <= S_DIFF;
          end else begin
            cnt_r <= cnt_r + CNTW'(1);
          end
        end

        S_DIFF: begin
          acc_r   <= alu_neg ? '0 : alu_y[DW-1:0];
          t_r     <= '0;
          root_r  <= '0;
          state_r <= S_SQRT;
        end

        // Integer square root, two radicand bits and one root bit a cycle.
        S_SQRT: begin
          t_r    <= sqrt_ok ? DW'(alu_y[RW:0]) : DW'(sqrt_trem);
          acc_r  <= {acc_r[DW-3:0], 2'b00};
          root_r <= {root_r[RW-2:0], sqrt_ok};
          if (cnt_r == CNTW'(RW - 1)) begin
            cnt_r        <= '0;
            quo_r        <= {root_r[RW-2:0], sqrt_ok};
            rem_r        <= '0;
            div_spread_r <= 1'b1;
            state_r      <= S_DIV;
          end else begin
            cnt_r <= cnt_r + CNTW'(1);
          end
        end

        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_mean_r   <= res_mean_r;
            out_spread_r <= res_spread_r;
            out_points_r <= PTS_W'(tally_r);
            out_ovf_r    <= dropped_r;
            tally_r      <= '0;
            dropped_r    <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++) begin
              sum_r[i] <= '0;
              sq_r[i]  <= '0;
            end
            axis_r  <= '0;
            state_r <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mean_x         = out_mean_r[0];
  assign out_mean_y         = out_mean_r[1];
  assign out_mean_z         = out_mean_r[2];
  assign out_spread_x       = out_spread_r[0];
  assign out_spread_y       = out_spread_r[1];
  assign out_spread_z       = out_spread_r[2];
  assign out_points_used    = out_points_r;
  assign out_count_overflow = out_ovf_r;

`ifndef ASSERT_OFF
  // The point count never passes the configured maximum.
  a_tally_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tally_r <= NW'(MAX_POINTS))
    else $error("point count above maximum");

  // A new result appears only from the end of the finish sequence.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside of finish");

  // Handing off a result starts a fresh set.
  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !(out_valid_r && out_stall))
      |=> (tally_r == '0 && !dropped_r && state_r == S_IDLE))
    else $error("accumulators not cleared after result");

  // The finish sequence always divides by a nonzero count.
  a_nonzero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV || state_r == S_MEAN_FIX || state_r == S_NSQ) |-> tally_r != '0)
    else $error("finish sequence running on an empty set");
`endif

endmodule
